### sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/imm_pkg.sv
package imm_pkg;

  localparam int MAX_DIM = 8;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 4;
  localparam int REQ_W   = 2;
  localparam int CIDX_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE_A = 2'd0,
    REQ_WRITE_B = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic lastk;
  } mac_tag_t;

  typedef struct packed {
    logic [DIM_W-1:0] ar_last;
    logic [DIM_W-1:0] ac_last;
    logic [DIM_W-1:0] bc_last;
    logic             mismatch;
  } dims_t;

  // last index of a dimension, with zero taken as one and large values as MAX_DIM
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(v - CFG_W'(1));
    end
    return r;
  endfunction

endpackage

### sv/imm_store.sv
module imm_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [imm_pkg::ADDR_W-1:0] waddr,
  input  logic [imm_pkg::DATA_W-1:0] wdata,
  input  logic [imm_pkg::ADDR_W-1:0] raddr,
  output logic [imm_pkg::DATA_W-1:0] rdata
);
  import imm_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/imm_mac.sv
module imm_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  imm_pkg::mac_tag_t          tag,
  input  logic [imm_pkg::DATA_W-1:0] a_q,
  input  logic [imm_pkg::DATA_W-1:0] b_q,
  output logic                       done,
  output logic [imm_pkg::DATA_W-1:0] acc
);
  import imm_pkg::*;

  mac_tag_t          tag_rd;
  mac_tag_t          tag_mul;
  logic [DATA_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd  <= '0;
      tag_mul <= '0;
      done    <= 1'b0;
    end else begin
      tag_rd  <= tag;
      tag_mul <= tag_rd;
      done    <= tag_mul.vld && tag_mul.lastk;
    end
  end

  // low 32 bits of the product are the same signed or unsigned
  always_ff @(posedge clk) begin
    if (tag_rd.vld) begin
      prod <= a_q * b_q;
    end
    if (tag_mul.vld) begin
      acc <= tag_mul.first ? prod : acc + prod;
    end
  end

endmodule

### sv/imm_seq.sv
`include "assert_macros.svh"

module imm_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  imm_pkg::dims_t             dims,
  input  logic                       mac_done,
  input  logic [imm_pkg::DATA_W-1:0] acc,
  input  logic                       out_stall,
  output logic                       busy,
  output logic [imm_pkg::ADDR_W-1:0] a_addr,
  output logic [imm_pkg::ADDR_W-1:0] b_addr,
  output imm_pkg::mac_tag_t          tag,
  output logic                       out_valid,
  output logic [imm_pkg::DATA_W-1:0] product_value,
  output logic [imm_pkg::DIM_W-1:0]  out_row,
  output logic [imm_pkg::DIM_W-1:0]  out_col,
  output logic                       size_error,
  output logic                       last
);
  import imm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [DIM_W-1:0] i;
  logic [DIM_W-1:0] j;
  logic [DIM_W-1:0] k;
  logic             err;
  logic             load;
  logic             last_elem;

  assign busy      = (state != S_IDLE);
  assign a_addr    = {i, k};
  assign b_addr    = {k, j};
  assign tag.vld   = (state == S_ISSUE);
  assign tag.first = (k == '0);
  assign tag.lastk = (k == dims.ac_last);
  assign load      = (state == S_EMIT) && (!out_valid || !out_stall);
  assign last_elem = err || ((i == dims.ar_last) && (j == dims.bc_last));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (go) begin
          state_next = dims.mismatch ? S_EMIT : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (tag.lastk) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_next = last_elem ? S_IDLE : S_ISSUE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && go) begin
      err <= dims.mismatch;
      i   <= '0;
      j   <= '0;
      k   <= '0;
    end
    if (state == S_ISSUE) begin
      k <= tag.lastk ? '0 : k + DIM_W'(1);
    end
    if (load) begin
      product_value <= err ? '0 : acc;
      out_row       <= err ? '0 : i;
      out_col       <= err ? '0 : j;
      size_error    <= err;
      last          <= last_elem;
      if (!last_elem) begin
        if (j == dims.bc_last) begin
          j <= '0;
          i <= i + DIM_W'(1);
        end else begin
          j <= j + DIM_W'(1);
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_rst_idle, clk, rst |=> (state == S_IDLE) && !out_valid, "reset not idle")
  `ASSERT_RST(a_done_wait, clk, rst, mac_done |-> state == S_WAIT, "mac done outside wait")
  `ASSERT_RST(a_err_last, clk, rst, out_valid && size_error |-> last, "error result not last")
  `ASSERT_RST(a_idx_range, clk, rst,
    busy |-> (i <= dims.ar_last) && (j <= dims.bc_last), "element index out of range")

endmodule

### sv/integer_matrix_multiplier_core.sv
// integer matrix multiplier, 32-bit signed elements, up to 8 x 8
// config: cfg_valid/cfg_ready with cfg_index (0 a_rows, 1 a_cols, 2 b_rows,
// 3 b_cols) and cfg_data; cfg_ready is always high, write only while idle
// input: in_valid/in_stall; req_type 0 and 1 write element_value into the first
// or second matrix at row_index, col_index; req_type 2 computes
// output: out_valid/out_stall; the product row-major, one element per transaction
// with out_row, out_col and last on the final one; mismatched inner dimensions
// give a single transaction with size_error and last set and zero payload
// each element of a compute runs a_cols multiply-accumulates through the one shared
// multiplier, then waits for the read, multiply and accumulate registers to drain
// before the output register is loaded; in_stall is high for the whole compute
// when the receiver stalls, the output register holds its element and the
// sequencer waits before loading the next one
// reset returns the sequencer to idle, drops out_valid and sets all dimensions
// to 8; the matrix stores are not cleared and must be written before use
module integer_matrix_multiplier_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [imm_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [imm_pkg::REQ_W-1:0]         req_type,
  input  logic [imm_pkg::DIM_W-1:0]         row_index,
  input  logic [imm_pkg::DIM_W-1:0]         col_index,
  input  logic signed [imm_pkg::DATA_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [imm_pkg::DATA_W-1:0] product_value,
  output logic [imm_pkg::DIM_W-1:0]         out_row,
  output logic [imm_pkg::DIM_W-1:0]         out_col,
  output logic                              size_error,
  output logic                              last
);
  import imm_pkg::*;

  logic [CFG_W-1:0]  a_rows;
  logic [CFG_W-1:0]  a_cols;
  logic [CFG_W-1:0]  b_rows;
  logic [CFG_W-1:0]  b_cols;
  dims_t             dims;
  logic              in_acc;
  logic              we_a;
  logic              we_b;
  logic              go;
  logic              busy;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] prod_q;
  logic              mac_done;
  mac_tag_t          tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= CFG_W'(MAX_DIM);
      a_cols <= CFG_W'(MAX_DIM);
      b_rows <= CFG_W'(MAX_DIM);
      b_cols <= CFG_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_A_ROWS: a_rows <= cfg_data;
        CFG_A_COLS: a_cols <= cfg_data;
        CFG_B_ROWS: b_rows <= cfg_data;
        CFG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dims.ar_last  = dim_last(a_rows);
  assign dims.ac_last  = dim_last(a_cols);
  assign dims.bc_last  = dim_last(b_cols);
  assign dims.mismatch = (dim_last(a_cols) != dim_last(b_rows));

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;
  assign we_a     = in_acc && (req_type == REQ_WRITE_A);
  assign we_b     = in_acc && (req_type == REQ_WRITE_B);
  assign go       = in_acc && (req_type == REQ_COMPUTE);
  assign waddr    = {row_index, col_index};

  imm_store u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (a_addr),
    .rdata (a_q)
  );

  imm_store u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (b_addr),
    .rdata (b_q)
  );

  imm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .tag  (tag),
    .a_q  (a_q),
    .b_q  (b_q),
    .done (mac_done),
    .acc  (acc)
  );

  imm_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .dims          (dims),
    .mac_done      (mac_done),
    .acc           (acc),
    .out_stall     (out_stall),
    .busy          (busy),
    .a_addr        (a_addr),
    .b_addr        (b_addr),
    .tag           (tag),
    .out_valid     (out_valid),
    .product_value (prod_q),
    .out_row       (out_row),
    .out_col       (out_col),
    .size_error    (size_error),
    .last          (last)
  );

  assign product_value = signed'(prod_q);

endmodule

### dv/imm_product_monitor.sv
`timescale 1ns / 1ps
module imm_product_monitor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [imm_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [imm_pkg::REQ_W-1:0]         req_type,
  input  logic [imm_pkg::DIM_W-1:0]         row_index,
  input  logic [imm_pkg::DIM_W-1:0]         col_index,
  input  logic signed [imm_pkg::DATA_W-1:0] element_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [imm_pkg::DATA_W-1:0] product_value,
  input  logic [imm_pkg::DIM_W-1:0]         out_row,
  input  logic [imm_pkg::DIM_W-1:0]         out_col,
  input  logic                              size_error,
  input  logic                              last,
  output int unsigned                       fail_count,
  output int unsigned                       pending_count
);
  import imm_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] elem;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic              err;
    logic              last_flag;
  } product_elem_t;

  logic [DATA_W-1:0] first_mat  [DEPTH];
  logic [DATA_W-1:0] second_mat [DEPTH];
  logic [CFG_W-1:0]  a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  product_elem_t     expected_products [$];

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  // zero counts as one, anything above the store size as the store size
  function automatic int dim_count(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic predict_product();
    int ar, ac, br, bc;
    logic [DATA_W-1:0] acc;
    product_elem_t e;
    ar = dim_count(a_rows_q);
    ac = dim_count(a_cols_q);
    br = dim_count(b_rows_q);
    bc = dim_count(b_cols_q);
    if (ac != br) begin
      e = '{elem: '0, row: '0, col: '0, err: 1'b1, last_flag: 1'b1};
      expected_products.push_back(e);
    end else begin
      for (int i = 0; i < ar; i++) begin
        for (int j = 0; j < bc; j++) begin
          acc = '0;
          for (int k = 0; k < ac; k++) begin
            acc = acc + first_mat[i * MAX_DIM + k] * second_mat[k * MAX_DIM + j];
          end
          e.elem = acc;
          e.row = DIM_W'(i);
          e.col = DIM_W'(j);
          e.err = 1'b0;
          e.last_flag = (i == ar - 1) && (j == bc - 1);
          expected_products.push_back(e);
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    product_elem_t e;
    if (rst) begin
      a_rows_q = CFG_W'(MAX_DIM);
      a_cols_q = CFG_W'(MAX_DIM);
      b_rows_q = CFG_W'(MAX_DIM);
      b_cols_q = CFG_W'(MAX_DIM);
      expected_products.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_products.size() == 0) begin
          $error("unexpected product transaction: row %0d col %0d", out_row, out_col);
          fail_count++;
        end else begin
          e = expected_products.pop_front();
          if (product_value !== e.elem) begin
            $error("product_value expected %0d actual %0d", $signed(e.elem), product_value);
            fail_count++;
          end
          if (out_row !== e.row) begin
            $error("out_row expected %0d actual %0d", e.row, out_row);
            fail_count++;
          end
          if (out_col !== e.col) begin
            $error("out_col expected %0d actual %0d", e.col, out_col);
            fail_count++;
          end
          if (size_error !== e.err) begin
            $error("size_error expected %0b actual %0b", e.err, size_error);
            fail_count++;
          end
          if (last !== e.last_flag) begin
            $error("last expected %0b actual %0b", e.last_flag, last);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_A_ROWS: a_rows_q = cfg_data;
          CFG_A_COLS: a_cols_q = cfg_data;
          CFG_B_ROWS: b_rows_q = cfg_data;
          CFG_B_COLS: b_cols_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (req_type)
          REQ_WRITE_A: first_mat[{row_index, col_index}] = element_value;
          REQ_WRITE_B: second_mat[{row_index, col_index}] = element_value;
          REQ_COMPUTE: predict_product();
          default: ;
        endcase
      end
    end
    pending_count = expected_products.size();
  end

endmodule

### dv/integer_matrix_multiplier_core_tb.sv
`timescale 1ns / 1ps
module integer_matrix_multiplier_core_tb;
  import imm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 260;
  localparam int LONG_HOLD = 400;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [REQ_W-1:0]         req_type = '0;
  logic [DIM_W-1:0]         row_index = '0;
  logic [DIM_W-1:0]         col_index = '0;
  logic signed [DATA_W-1:0] element_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] product_value;
  logic [DIM_W-1:0]         out_row;
  logic [DIM_W-1:0]         out_col;
  logic                     size_error;
  logic                     last;
  int unsigned              fail_count;
  int unsigned              pending_count;

  logic [CFG_W-1:0] cur_ar = CFG_W'(MAX_DIM);
  logic [CFG_W-1:0] cur_ac = CFG_W'(MAX_DIM);
  logic [CFG_W-1:0] cur_br = CFG_W'(MAX_DIM);
  logic [CFG_W-1:0] cur_bc = CFG_W'(MAX_DIM);
  bit               a_written [DEPTH];
  bit               b_written [DEPTH];
  int               burst_left = 0;
  int               items_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  integer_matrix_multiplier_core u_top (.*);

  imm_product_monitor u_monitor (.*);

  function automatic int dim_count(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [DATA_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      default: return 4'd15;
    endcase
  endfunction

  task automatic cfg_put(input cfg_idx_t idx, input logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] ac,
                          input logic [CFG_W-1:0] br, input logic [CFG_W-1:0] bc);
    cur_ar = ar;
    cur_ac = ac;
    cur_br = br;
    cur_bc = bc;
    cfg_put(CFG_A_ROWS, ar);
    cfg_put(CFG_A_COLS, ac);
    cfg_put(CFG_B_ROWS, br);
    cfg_put(CFG_B_COLS, bc);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [REQ_W-1:0] rq, input logic [DIM_W-1:0] r,
                           input logic [DIM_W-1:0] c, input logic [DATA_W-1:0] v);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    row_index <= r;
    col_index <= c;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (rq == REQ_WRITE_A) a_written[{r, c}] = 1'b1;
    else if (rq == REQ_WRITE_B) b_written[{r, c}] = 1'b1;
    if (rq != REQ_UNUSED) items_sent++;
  endtask

  // fill any entry the product reads that was never written, then compute
  task automatic issue_compute();
    int ar, ac, br, bc;
    ar = dim_count(cur_ar);
    ac = dim_count(cur_ac);
    br = dim_count(cur_br);
    bc = dim_count(cur_bc);
    if (ac == br) begin
      for (int i = 0; i < ar; i++) begin
        for (int k = 0; k < ac; k++) begin
          if (!a_written[i * MAX_DIM + k])
            send_item(REQ_WRITE_A, DIM_W'(i), DIM_W'(k), rand_elem());
        end
      end
      for (int k = 0; k < br; k++) begin
        for (int j = 0; j < bc; j++) begin
          if (!b_written[k * MAX_DIM + j])
            send_item(REQ_WRITE_B, DIM_W'(k), DIM_W'(j), rand_elem());
        end
      end
    end
    send_item(REQ_COMPUTE, DIM_W'($urandom), DIM_W'($urandom), $urandom);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_count != 0);
    repeat (16) @(posedge clk);
  endtask

  // output stall pattern, with one long hold while the sender keeps offering
  initial begin : rx_pattern
    int cyc, hold_left, mode, mode_left;
    bit held;
    cyc = 0;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && cyc > 300 && out_valid && in_valid && in_stall) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= cyc[0];
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] ar, ac, br, bc;
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 1 x 1 with wrapping extremes, unused request code must leave stores alone
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    send_item(REQ_WRITE_A, 3'd0, 3'd0, 32'h8000_0000);
    send_item(REQ_WRITE_B, 3'd0, 3'd0, 32'h8000_0000);
    send_item(REQ_COMPUTE, 3'd0, 3'd0, '0);
    send_item(REQ_UNUSED, 3'd0, 3'd0, 32'h1234_5678);
    send_item(REQ_UNUSED, 3'd7, 3'd7, 32'hffff_ffff);
    send_item(REQ_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
    send_item(REQ_WRITE_A, 3'd0, 3'd0, 32'h7fff_ffff);
    send_item(REQ_WRITE_B, 3'd0, 3'd0, 32'h7fff_ffff);
    send_item(REQ_COMPUTE, 3'd0, 3'd0, '0);
    send_item(REQ_WRITE_B, 3'd0, 3'd0, 32'h8000_0000);
    send_item(REQ_COMPUTE, 3'd0, 3'd0, '0);
    send_item(REQ_WRITE_A, 3'd7, 3'd7, 32'hffff_ffff);
    send_item(REQ_WRITE_B, 3'd7, 3'd7, 32'h8000_0000);
    // zero dimensions count as one
    settle();
    set_dims(4'd0, 4'd0, 4'd0, 4'd0);
    issue_compute();
    // inner dimension mismatch
    settle();
    set_dims(4'd2, 4'd3, 4'd4, 4'd2);
    issue_compute();
    // oversized inner dimensions clamp to full width
    settle();
    set_dims(4'd1, 4'd15, 4'd8, 4'd1);
    issue_compute();
    // full 8 x 8 output from an outer product
    settle();
    set_dims(4'd8, 4'd0, 4'd1, 4'd8);
    issue_compute();
    settle();
    set_dims(4'd3, 4'd8, 4'd7, 4'd3);
    issue_compute();

    while (items_sent < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 11))
        0, 1: begin
          ar = $urandom_range(0, 15);
          ac = $urandom_range(0, 15);
          br = $urandom_range(0, 15);
          bc = $urandom_range(0, 15);
        end
        2: begin
          ar = 4'd8;
          ac = 4'd8;
          br = 4'd8;
          bc = 4'd8;
        end
        3, 4: begin
          ar = pick_extreme();
          ac = pick_extreme();
          br = (dim_count(ac) == 1) ? 4'($urandom_range(0, 1)) :
               ($urandom_range(0, 1) ? 4'd8 : 4'd15);
          bc = pick_extreme();
        end
        default: begin
          ar = $urandom_range(1, 4);
          ac = $urandom_range(1, 4);
          br = ac;
          bc = $urandom_range(1, 4);
        end
      endcase
      set_dims(ar, ac, br, bc);
      n = $urandom_range(4, 24);
      repeat (n) begin
        case ($urandom_range(0, 11))
          0: send_item(REQ_UNUSED, DIM_W'($urandom), DIM_W'($urandom), $urandom);
          1, 2: send_item($urandom_range(0, 1) ? REQ_WRITE_B : REQ_WRITE_A,
                          DIM_W'($urandom), DIM_W'($urandom), rand_elem());
          3, 4: issue_compute();
          default: begin
            if ($urandom_range(0, 1))
              send_item(REQ_WRITE_A, DIM_W'($urandom_range(0, dim_count(cur_ar) - 1)),
                        DIM_W'($urandom_range(0, dim_count(cur_ac) - 1)), rand_elem());
            else
              send_item(REQ_WRITE_B, DIM_W'($urandom_range(0, dim_count(cur_br) - 1)),
                        DIM_W'($urandom_range(0, dim_count(cur_bc) - 1)), rand_elem());
          end
        endcase
      end
      issue_compute();
    end

    settle();
    if (fail_count == 0) begin
      $display("integer_matrix_multiplier_core_tb OK");
    end else begin
      $display("integer_matrix_multiplier_core_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("integer_matrix_multiplier_core_tb NOT OK");
    $finish;
  end

endmodule
